FILE: rtl/core/lsd_pkg.sv
// lsd_pkg: shared widths, config register indexes and the config bundle
// for the laplacian sharpen / dither block. no dependencies.
package lsd_pkg;

  localparam int PIX_W               = 14;
  localparam int RND_W               = 16;
  localparam int STRENGTH_W          = 16;
  localparam int DSTR_W              = 8;
  localparam int CFG_DATA_W          = 16;
  localparam int SAMPLE_BITS_DEFAULT = 14;
  localparam int SAMPLE_BITS_MIN     = 8;
  localparam int SAMPLE_BITS_MAX     = 14;

  localparam logic [PIX_W-1:0] CLAMP_MAX_RESET = 14'd255;

  typedef enum logic [1:0] {
    CFG_STRENGTH_CODE   = 2'd0,
    CFG_CLAMP_MAX       = 2'd1,
    CFG_DITHER_ENABLE   = 2'd2,
    CFG_DITHER_STRENGTH = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [STRENGTH_W-1:0] strength_code;
    logic [PIX_W-1:0]      clamp_limit;
    logic                  dither_enable;
    logic [DSTR_W-1:0]     dither_strength;
  } lsd_cfg_t;

endpackage

FILE: rtl/core/lsd_sharpen.sv
// lsd_sharpen: five-point laplacian weight, signed gain correction and clamp.
// the raw weight is added too for negative gain codes. depends on lsd_pkg.
module lsd_sharpen
  import lsd_pkg::*;
(
  input  logic [PIX_W-1:0] center_pixel,
  input  logic [PIX_W-1:0] left_pixel,
  input  logic [PIX_W-1:0] right_pixel,
  input  logic [PIX_W-1:0] top_pixel,
  input  logic [PIX_W-1:0] bottom_pixel,
  input  lsd_cfg_t         cfg,
  output logic [PIX_W-1:0] sharp_pixel
);

  logic        [15:0] nb_sum;
  logic        [15:0] center_x4;
  logic signed [17:0] weight;
  logic signed [15:0] gain;
  logic signed [33:0] prod;
  logic signed [33:0] rounded;
  logic signed [17:0] corr;
  logic signed [19:0] weight_add;
  logic signed [19:0] sum;

  always_comb begin
    nb_sum     = 16'(left_pixel) + 16'(right_pixel) + 16'(top_pixel) + 16'(bottom_pixel);
    center_x4  = {center_pixel, 2'b00};
    weight     = $signed({2'b00, center_x4}) - $signed({2'b00, nb_sum});
    gain       = $signed(cfg.strength_code);
    prod       = 34'(weight) * 34'(gain);
    rounded    = prod + 34'sd32768;
    corr       = rounded[33:16];
    // add-weight mode when the gain code is negative
    weight_add = cfg.strength_code[STRENGTH_W-1] ? 20'(weight) : 20'sd0;
    sum        = $signed({6'b0, center_pixel}) + 20'(corr) + weight_add;
    if (sum < 20'sd0) begin
      sharp_pixel = '0;
    end else if (sum > $signed({6'b0, cfg.clamp_limit})) begin
      sharp_pixel = cfg.clamp_limit;
    end else begin
      sharp_pixel = sum[PIX_W-1:0];
    end
  end

endmodule

FILE: rtl/core/lsd_dither.sv
// lsd_dither: adds the scaled random dither term and clamps again.
// bypassed while dither_enable is low. depends on lsd_pkg.
module lsd_dither
  import lsd_pkg::*;
(
  input  logic [PIX_W-1:0] sharp_pixel,
  input  logic [RND_W-1:0] dither_random,
  input  lsd_cfg_t         cfg,
  output logic [PIX_W-1:0] dithered_pixel
);

  logic        [8:0]  mul;
  logic        [24:0] prod;
  logic        [8:0]  scaled;
  logic signed [9:0]  dval;
  logic signed [15:0] sum;

  always_comb begin
    mul    = {cfg.dither_strength, 1'b1};
    prod   = {9'b0, dither_random} * {16'b0, mul};
    scaled = prod[24:16];
    dval   = $signed({2'b00, cfg.dither_strength}) - $signed({1'b0, scaled});
    sum    = $signed({2'b00, sharp_pixel}) + 16'(dval);
    if (!cfg.dither_enable) begin
      dithered_pixel = sharp_pixel;
    end else if (sum < 16'sd0) begin
      dithered_pixel = '0;
    end else if (sum > $signed({2'b00, cfg.clamp_limit})) begin
      dithered_pixel = cfg.clamp_limit;
    end else begin
      dithered_pixel = sum[PIX_W-1:0];
    end
  end

endmodule

FILE: rtl/core/laplacian_sharpen_dither.sv
// laplacian_sharpen_dither: top level, input register, sharpen and dither logic,
// result register. depends on lsd_pkg, lsd_sharpen, lsd_dither.
// path from input accept to out_valid: input register, then result register.
// throughput: one item per cycle; in_stall only while both registers hold items
// and out_stall is high.
// reset: synchronous active-low rst_n empties both registers and loads register defaults.
module laplacian_sharpen_dither
  import lsd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIX_W-1:0]      in_center_pixel,
  input  logic [PIX_W-1:0]      in_left_pixel,
  input  logic [PIX_W-1:0]      in_right_pixel,
  input  logic [PIX_W-1:0]      in_top_pixel,
  input  logic [PIX_W-1:0]      in_bottom_pixel,
  input  logic [RND_W-1:0]      in_dither_random,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIX_W-1:0]      out_sharpened_pixel,
  input  logic                  cfg_we,
  input  cfg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [PIX_W-1:0] DEPTH_MAX = PIX_W'((1 << SAMPLE_BITS) - 1);

  lsd_cfg_t         cfg_r;
  logic [PIX_W-1:0] limit_nxt;

  logic             s1_valid_r;
  logic [PIX_W-1:0] center_r;
  logic [PIX_W-1:0] left_r;
  logic [PIX_W-1:0] right_r;
  logic [PIX_W-1:0] top_r;
  logic [PIX_W-1:0] bottom_r;
  logic [RND_W-1:0] random_r;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_pixel_r;
  logic [PIX_W-1:0] sharp_pixel;
  logic [PIX_W-1:0] out_pixel_nxt;

  logic             s2_ready;
  logic             s1_ready;
  logic             in_accept;

  // config registers, clamp limit folded against sample depth on write
  assign limit_nxt = (cfg_wdata[PIX_W-1:0] > DEPTH_MAX) ? DEPTH_MAX : cfg_wdata[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.strength_code   <= '0;
      cfg_r.clamp_limit     <= (CLAMP_MAX_RESET > DEPTH_MAX) ? DEPTH_MAX : CLAMP_MAX_RESET;
      cfg_r.dither_enable   <= 1'b0;
      cfg_r.dither_strength <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STRENGTH_CODE:   cfg_r.strength_code   <= cfg_wdata[STRENGTH_W-1:0];
        CFG_CLAMP_MAX:       cfg_r.clamp_limit     <= limit_nxt;
        CFG_DITHER_ENABLE:   cfg_r.dither_enable   <= cfg_wdata[0];
        CFG_DITHER_STRENGTH: cfg_r.dither_strength <= cfg_wdata[DSTR_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign s2_ready  = !out_valid_r || !out_stall;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_stall  = !s1_ready;
  assign in_accept = in_valid && s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      center_r <= in_center_pixel;
      left_r   <= in_left_pixel;
      right_r  <= in_right_pixel;
      top_r    <= in_top_pixel;
      bottom_r <= in_bottom_pixel;
      random_r <= in_dither_random;
    end
  end

  lsd_sharpen u_sharpen (
    .center_pixel (center_r),
    .left_pixel   (left_r),
    .right_pixel  (right_r),
    .top_pixel    (top_r),
    .bottom_pixel (bottom_r),
    .cfg          (cfg_r),
    .sharp_pixel  (sharp_pixel)
  );

  lsd_dither u_dither (
    .sharp_pixel    (sharp_pixel),
    .dither_random  (random_r),
    .cfg            (cfg_r),
    .dithered_pixel (out_pixel_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      out_pixel_r <= out_pixel_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_sharpened_pixel = out_pixel_r;

endmodule

FILE: rtl/core/lsd_checker.sv
// lsd_checker: port-level assertions for laplacian_sharpen_dither, bound to the top level.
// depends on lsd_pkg and laplacian_sharpen_dither.
module lsd_checker
  import lsd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [PIX_W-1:0] out_sharpened_pixel
);

  localparam logic [PIX_W-1:0] DEPTH_MAX = PIX_W'((1 << SAMPLE_BITS) - 1);

  // nothing left after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sharpened_pixel))
    else $error("stalled item changed");

  // input backs up only when the result side is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without output backpressure");

  // out_valid is high once an accepted item has passed the input register and the result register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> ##1 out_valid)
    else $error("item did not reach output");

  // result never exceeds sample depth
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sharpened_pixel <= DEPTH_MAX)
    else $error("result above sample depth");

endmodule

bind laplacian_sharpen_dither lsd_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_lsd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_sharpened_pixel (out_sharpened_pixel)
);
